[sv/riff_wave_header_parser_macros.svh]
// Assertion helpers used by the parser top level.
`ifndef RIFF_WAVE_HEADER_PARSER_MACROS_SVH
`define RIFF_WAVE_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RWP_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rwp: check failed");

// Next-cycle implication.
`define RWP_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rwp: check failed");

`endif

[sv/rwp_pkg.sv]
`default_nettype none

package rwp_pkg;

   localparam logic [31:0] ID_RIFF = 32'h5249_4646;
   localparam logic [31:0] ID_WAVE = 32'h5741_5645;
   localparam logic [31:0] ID_FMT  = 32'h666D_7420;
   localparam logic [31:0] ID_DATA = 32'h6461_7461;
   localparam logic [15:0] PCM_TAG = 16'd1;
   localparam logic [31:0] FMT_MIN_LEN = 32'd16;

   localparam logic [1:0] KIND_REPORT = 2'd0;
   localparam logic [1:0] KIND_AUDIO  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_NOT_RIFF  = 3'd0;
   localparam logic [2:0] ERR_NOT_WAVE  = 3'd1;
   localparam logic [2:0] ERR_FMT_BAD   = 3'd2;
   localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
   localparam logic [2:0] ERR_DATA_BAD  = 3'd4;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_RIFF_ID   = 4'd0,
      PH_RIFF_SIZE = 4'd1,
      PH_WAVE_ID   = 4'd2,
      PH_CHUNK_ID  = 4'd3,
      PH_CHUNK_LEN = 4'd4,
      PH_FMT_BODY  = 4'd5,
      PH_SKIP      = 4'd6,
      PH_DATA      = 4'd7,
      PH_DONE      = 4'd8,
      PH_ERROR     = 4'd9
   } rwp_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } rwp_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  audio_byte;
      logic        last_of_data;
      logic [15:0] channels;
      logic [31:0] sample_rate;
      logic [31:0] bytes_per_second;
      logic [15:0] block_align;
      logic [15:0] bits_per_sample;
      logic [31:0] data_size;
      logic [2:0]  error_code;
      logic        last;
   } rwp_rsp_type;

   // results of one accepted item, in delivery order
   typedef struct packed {
      logic        first_valid;
      logic        second_valid;
      rwp_rsp_type first_item;
      rwp_rsp_type second_item;
   } rwp_push_type;

endpackage

`default_nettype wire

[sv/rwp_parse.sv]
`default_nettype none

module rwp_parse (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire rwp_pkg::rwp_req_type req,
   output rwp_pkg::rwp_push_type     push
);

   rwp_pkg::rwp_phase_type phase_ff, phase_in, phase_mid;
   logic [3:0]  count_ff, count_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] len_ff, len_in;
   logic        pad_ff, pad_in;
   logic        fmt_found_ff, fmt_found_in, fmt_found_mid;
   logic [15:0] tag_ff, tag_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] brate_ff, brate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] depth_ff, depth_in;

   logic [31:0] id_next;
   logic [3:0]  count_inc;
   logic        id_done;
   logic [15:0] b16_sh;
   logic [31:0] b32_sh;
   logic [31:0] len_acc;
   logic [31:0] len_dec;
   logic [31:0] fmt_rem;
   logic [15:0] tag_next;
   logic [31:0] skip_len;
   logic        skip_pad;
   logic        len_end;
   logic        ev_riff_bad, ev_wave_bad, ev_fmt, ev_fmt_short, ev_not_pcm;
   logic        ev_report, ev_audio, byte_err, byte_valid, eof_err;
   logic [2:0]  byte_err_code, eof_err_code;
   rwp_pkg::rwp_rsp_type byte_item, eof_item;

   // shared decode of the current byte
   always_comb begin
      id_next   = {id_ff[23:0], req.data_byte};
      count_inc = count_ff + 4'd1;
      id_done   = (count_ff[1:0] == 2'd3);
      b16_sh    = {8'd0, req.data_byte} << {count_ff[0], 3'b000};
      b32_sh    = {24'd0, req.data_byte} << {count_ff[1:0], 3'b000};
      len_acc   = len_ff | b32_sh;
      len_dec   = len_ff - 32'd1;
      fmt_rem   = len_ff - rwp_pkg::FMT_MIN_LEN;
      tag_next  = tag_ff | b16_sh;
      skip_len  = (len_ff != 32'd0) ? len_dec : 32'd0;
      skip_pad  = (len_ff != 32'd0) ? pad_ff : 1'b0;
      len_end   = (phase_ff == rwp_pkg::PH_CHUNK_LEN) && id_done;

      ev_riff_bad  = (phase_ff == rwp_pkg::PH_RIFF_ID) && id_done
                     && (id_next != rwp_pkg::ID_RIFF);
      ev_wave_bad  = (phase_ff == rwp_pkg::PH_WAVE_ID) && id_done
                     && (id_next != rwp_pkg::ID_WAVE);
      ev_fmt       = len_end && (id_ff == rwp_pkg::ID_FMT) && !fmt_found_ff;
      ev_fmt_short = ev_fmt && (len_acc < rwp_pkg::FMT_MIN_LEN);
      ev_report    = len_end && (id_ff == rwp_pkg::ID_DATA) && fmt_found_ff;
      ev_not_pcm   = (phase_ff == rwp_pkg::PH_FMT_BODY) && (count_ff == 4'd1)
                     && (tag_next != rwp_pkg::PCM_TAG);
      ev_audio     = (phase_ff == rwp_pkg::PH_DATA);

      byte_err = ev_riff_bad || ev_wave_bad || ev_fmt_short || ev_not_pcm;
      if (ev_riff_bad) begin
         byte_err_code = rwp_pkg::ERR_NOT_RIFF;
      end else if (ev_wave_bad) begin
         byte_err_code = rwp_pkg::ERR_NOT_WAVE;
      end else if (ev_fmt_short) begin
         byte_err_code = rwp_pkg::ERR_FMT_BAD;
      end else begin
         byte_err_code = rwp_pkg::ERR_NOT_PCM;
      end
   end

   // next state
   always_comb begin
      phase_mid    = phase_ff;
      count_in     = count_ff;
      id_in        = id_ff;
      len_in       = len_ff;
      pad_in       = pad_ff;
      fmt_found_in = fmt_found_ff;
      tag_in       = tag_ff;
      chan_in      = chan_ff;
      rate_in      = rate_ff;
      brate_in     = brate_ff;
      align_in     = align_ff;
      depth_in     = depth_ff;

      unique case (phase_ff)
         rwp_pkg::PH_RIFF_ID, rwp_pkg::PH_WAVE_ID, rwp_pkg::PH_CHUNK_ID: begin
            id_in    = id_next;
            count_in = id_done ? 4'd0 : count_inc;
            if (id_done) begin
               if (phase_ff == rwp_pkg::PH_RIFF_ID) begin
                  phase_mid = ev_riff_bad ? rwp_pkg::PH_ERROR : rwp_pkg::PH_RIFF_SIZE;
               end else if (phase_ff == rwp_pkg::PH_WAVE_ID) begin
                  phase_mid = ev_wave_bad ? rwp_pkg::PH_ERROR : rwp_pkg::PH_CHUNK_ID;
               end else begin
                  len_in    = 32'd0;
                  phase_mid = rwp_pkg::PH_CHUNK_LEN;
               end
            end
         end
         rwp_pkg::PH_RIFF_SIZE: begin
            count_in = id_done ? 4'd0 : count_inc;
            if (id_done) begin
               phase_mid = rwp_pkg::PH_WAVE_ID;
            end
         end
         rwp_pkg::PH_CHUNK_LEN: begin
            len_in   = len_acc;
            count_in = id_done ? 4'd0 : count_inc;
            if (id_done) begin
               pad_in = len_acc[0];
               if (ev_fmt) begin
                  phase_mid = ev_fmt_short ? rwp_pkg::PH_ERROR : rwp_pkg::PH_FMT_BODY;
               end else if (ev_report) begin
                  phase_mid = (len_acc == 32'd0) ? rwp_pkg::PH_DONE : rwp_pkg::PH_DATA;
               end else begin
                  // an even zero length has no pad byte, so nothing to skip
                  phase_mid = (len_acc == 32'd0) ? rwp_pkg::PH_CHUNK_ID : rwp_pkg::PH_SKIP;
               end
            end
         end
         rwp_pkg::PH_FMT_BODY: begin
            case (count_ff) inside
               4'd0, 4'd1:    tag_in   = tag_next;
               4'd2, 4'd3:    chan_in  = chan_ff | b16_sh;
               [4'd4:4'd7]:   rate_in  = rate_ff | b32_sh;
               [4'd8:4'd11]:  brate_in = brate_ff | b32_sh;
               4'd12, 4'd13:  align_in = align_ff | b16_sh;
               default:       depth_in = depth_ff | b16_sh;
            endcase
            count_in = count_inc;
            if (ev_not_pcm) begin
               phase_mid = rwp_pkg::PH_ERROR;
            end else if (count_ff == 4'd15) begin
               fmt_found_in = 1'b1;
               len_in       = fmt_rem;
               phase_mid    = (fmt_rem == 32'd0 && !pad_ff) ? rwp_pkg::PH_CHUNK_ID
                                                          : rwp_pkg::PH_SKIP;
            end
         end
         rwp_pkg::PH_SKIP: begin
            len_in = skip_len;
            pad_in = skip_pad;
            if (skip_len == 32'd0 && !skip_pad) begin
               phase_mid = rwp_pkg::PH_CHUNK_ID;
            end
         end
         rwp_pkg::PH_DATA: begin
            len_in = len_dec;
            if (len_dec == 32'd0) begin
               phase_mid = rwp_pkg::PH_DONE;
            end
         end
         default: begin
         end
      endcase

      fmt_found_mid = fmt_found_in;
      phase_in      = phase_mid;

      // end of file: everything back to its reset value
      if (req.end_of_file) begin
         phase_in     = rwp_pkg::PH_RIFF_ID;
         count_in     = '0;
         id_in        = '0;
         len_in       = '0;
         pad_in       = 1'b0;
         fmt_found_in = 1'b0;
         tag_in       = '0;
         chan_in      = '0;
         rate_in      = '0;
         brate_in     = '0;
         align_in     = '0;
         depth_in     = '0;
      end
   end

   // results
   always_comb begin
      eof_err = req.end_of_file && (phase_mid != rwp_pkg::PH_DONE)
                && (phase_mid != rwp_pkg::PH_ERROR);
      unique case (phase_mid)
         rwp_pkg::PH_RIFF_ID:                          eof_err_code = rwp_pkg::ERR_NOT_RIFF;
         rwp_pkg::PH_RIFF_SIZE, rwp_pkg::PH_WAVE_ID:   eof_err_code = rwp_pkg::ERR_NOT_WAVE;
         rwp_pkg::PH_FMT_BODY:                         eof_err_code = rwp_pkg::ERR_FMT_BAD;
         rwp_pkg::PH_DATA:                             eof_err_code = rwp_pkg::ERR_DATA_BAD;
         default: eof_err_code = fmt_found_mid ? rwp_pkg::ERR_DATA_BAD : rwp_pkg::ERR_FMT_BAD;
      endcase

      byte_valid = byte_err || ev_report || ev_audio;

      byte_item = '0;
      if (byte_err) begin
         byte_item.kind       = rwp_pkg::KIND_ERROR;
         byte_item.error_code = byte_err_code;
      end else if (ev_report) begin
         byte_item.kind             = rwp_pkg::KIND_REPORT;
         byte_item.channels         = chan_ff;
         byte_item.sample_rate      = rate_ff;
         byte_item.bytes_per_second = brate_ff;
         byte_item.block_align      = align_ff;
         byte_item.bits_per_sample  = depth_ff;
         byte_item.data_size        = len_acc;
      end else begin
         byte_item.kind         = rwp_pkg::KIND_AUDIO;
         byte_item.audio_byte   = req.data_byte;
         byte_item.last_of_data = (len_dec == 32'd0);
      end
      byte_item.last = !eof_err;

      eof_item            = '0;
      eof_item.kind       = rwp_pkg::KIND_ERROR;
      eof_item.error_code = eof_err_code;
      eof_item.last       = 1'b1;

      push.first_valid  = accept && (byte_valid || eof_err);
      push.second_valid = accept && byte_valid && eof_err;
      push.first_item   = byte_valid ? byte_item : eof_item;
      push.second_item  = eof_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rwp_pkg::PH_RIFF_ID;
         count_ff     <= '0;
         id_ff        <= '0;
         len_ff       <= '0;
         pad_ff       <= 1'b0;
         fmt_found_ff <= 1'b0;
         tag_ff       <= '0;
         chan_ff      <= '0;
         rate_ff      <= '0;
         brate_ff     <= '0;
         align_ff     <= '0;
         depth_ff     <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         id_ff        <= id_in;
         len_ff       <= len_in;
         pad_ff       <= pad_in;
         fmt_found_ff <= fmt_found_in;
         tag_ff       <= tag_in;
         chan_ff      <= chan_in;
         rate_ff      <= rate_in;
         brate_ff     <= brate_in;
         align_ff     <= align_in;
         depth_ff     <= depth_in;
      end
   end

endmodule

`default_nettype wire

[sv/riff_wave_header_parser.sv]
// The results of an accepted item are written into the result queue and offered on rsp behind any earlier results.
// One item per cycle while req_ready is high; an item that yields two results offers them on rsp one after the other.
// The rate is set by the 4-entry result queue: req_ready is high while two slots are free.
// Reset (synchronous, active high) returns the parser to expecting RIFF and empties the queue.
`default_nettype none

`include "riff_wave_header_parser_macros.svh"

module riff_wave_header_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire rwp_pkg::rwp_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rwp_pkg::rwp_rsp_type      rsp_data
);

   logic                  accept;
   logic                  pop;
   rwp_pkg::rwp_push_type push;
   logic [1:0]            n_push;

   rwp_pkg::rwp_rsp_type                 q_ff [rwp_pkg::QUEUE_DEPTH];
   logic [rwp_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [rwp_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [rwp_pkg::QUEUE_CNT_W-1:0]      cnt_ff, cnt_in;

   // room for the worst case of two results per item
   assign req_ready = (cnt_ff <= rwp_pkg::QUEUE_CNT_W'(rwp_pkg::QUEUE_DEPTH - 2));
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   rwp_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .push   (push)
   );

   always_comb begin
      n_push    = {1'b0, push.first_valid} + {1'b0, push.second_valid};
      wr_ptr_in = wr_ptr_ff + rwp_pkg::QUEUE_PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + rwp_pkg::QUEUE_PTR_W'(pop);
      cnt_in    = cnt_ff + rwp_pkg::QUEUE_CNT_W'(n_push) - rwp_pkg::QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         q_ff[wr_ptr_ff] <= push.first_item;
      end
      if (push.second_valid) begin
         q_ff[wr_ptr_ff + rwp_pkg::QUEUE_PTR_W'(1)] <= push.second_item;
      end
   end

   `RWP_ASSERT_IMP(a_room_on_accept, req_valid && req_ready, cnt_ff <= rwp_pkg::QUEUE_CNT_W'(rwp_pkg::QUEUE_DEPTH - 2))
   `RWP_ASSERT_IMP(a_pair_order, push.second_valid, push.first_valid && !push.first_item.last && push.second_item.last)
   `RWP_ASSERT_NXT(a_drain, rsp_valid && rsp_ready && !push.first_valid, cnt_ff == rwp_pkg::QUEUE_CNT_W'($past(cnt_ff) - 1'b1))

endmodule

`default_nettype wire
